// ===== rtl/vfcm_pkg.sv =====
// ----------------------------------------------------------------------------
// Voxel face cull mesher package
// Shared constants, queue entry type and position helper for the mesher.
// ----------------------------------------------------------------------------
`default_nettype none

package vfcm_pkg;

  localparam int CHUNK_SIDE  = 16;
  localparam int STORE_DEPTH = CHUNK_SIDE * CHUNK_SIDE * CHUNK_SIDE;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CELL_W      = 4;
  localparam int ID_W        = 8;
  localparam int CHUNK_W     = 12;
  localparam int POS_W       = 18;
  localparam int VIDX_W      = 16;
  localparam int NUM_FACES   = 6;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_MESH  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] CFG_CHUNK_X = 2'd0;
  localparam logic [1:0] CFG_CHUNK_Y = 2'd1;
  localparam logic [1:0] CFG_CHUNK_Z = 2'd2;
  localparam logic [1:0] CFG_AIR_ID  = 2'd3;

  localparam logic [1:0] TEX_SIDE   = 2'd0;
  localparam logic [1:0] TEX_TOP    = 2'd1;
  localparam logic [1:0] TEX_BOTTOM = 2'd2;

  localparam logic [1:0] CORNER_LAST = 2'd3;

  // Corner offset signs: bit 2 is x, bit 1 is y, bit 0 is z; a set bit is +1.
  localparam logic [2:0] CORNER_SIGN [NUM_FACES][4] = '{
    '{3'd2, 3'd3, 3'd1, 3'd0},
    '{3'd1, 3'd5, 3'd4, 3'd0},
    '{3'd2, 3'd6, 3'd4, 3'd0},
    '{3'd6, 3'd7, 3'd5, 3'd4},
    '{3'd3, 3'd7, 3'd6, 3'd2},
    '{3'd3, 3'd7, 3'd5, 3'd1}
  };

  localparam logic [1:0] FACE_KIND [NUM_FACES] = '{
    TEX_SIDE, TEX_BOTTOM, TEX_SIDE, TEX_SIDE, TEX_TOP, TEX_SIDE
  };

  typedef enum logic {
    JOB_MESH,
    JOB_CLEAR
  } job_kind_t;

  typedef struct packed {
    job_kind_t             kind;
    logic [CELL_W-1:0]     x;
    logic [CELL_W-1:0]     y;
    logic [CELL_W-1:0]     z;
    logic [NUM_FACES-1:0]  vis;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [CELL_W-1:0] x,
                                                  input logic [CELL_W-1:0] y,
                                                  input logic [CELL_W-1:0] z);
    int a;
    a = (int'(x) * CHUNK_SIDE + int'(y)) * CHUNK_SIDE + int'(z);
    return ADDR_W'(a);
  endfunction

  function automatic logic signed [POS_W-1:0] half_pos(
      input logic signed [CHUNK_W-1:0] chunk,
      input logic [CELL_W-1:0]         coord,
      input logic                      plus);
    int p;
    p = 2 * (CHUNK_SIDE * int'(chunk) + int'(coord)) + (plus ? 1 : -1);
    return POS_W'(p);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/vfcm_fifo.sv =====
// ----------------------------------------------------------------------------
// Voxel face cull mesher job queue
// Short queue that parts the classifying front end from the vertex emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module vfcm_fifo (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire vfcm_pkg::job_t     push_job,
  input  wire logic               pop,
  output vfcm_pkg::job_t          pop_job,
  output vfcm_pkg::q_status_t     status
);
  import vfcm_pkg::*;

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign pop_job      = mem_r[rd_ptr_r];
  assign status.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && status.full))
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && status.empty))
    else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

// ===== rtl/vfcm_front.sv =====
// ----------------------------------------------------------------------------
// Voxel face cull mesher front end
// Accepts transactions, owns the block store and classifies the six faces.
// ----------------------------------------------------------------------------
`default_nettype none

module vfcm_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_op,
  input  wire logic [vfcm_pkg::CELL_W-1:0]   in_cell_x,
  input  wire logic [vfcm_pkg::CELL_W-1:0]   in_cell_y,
  input  wire logic [vfcm_pkg::CELL_W-1:0]   in_cell_z,
  input  wire logic [vfcm_pkg::ID_W-1:0]     in_block_id,
  input  wire logic [vfcm_pkg::ID_W-1:0]     air_id,
  input  wire vfcm_pkg::q_status_t           q_status,
  output logic                               push,
  output vfcm_pkg::job_t                     push_job
);
  import vfcm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_PUSH
  } state_t;

  state_t               state_r;
  job_kind_t            kind_r;
  logic [CELL_W-1:0]    x_r, y_r, z_r;
  logic [2:0]           rd_idx_r;
  logic                 pend_r;
  logic [2:0]           pend_idx_r;
  logic                 solid_r;
  logic [NUM_FACES-1:0] vis_r;

  logic [ID_W-1:0]      store [STORE_DEPTH];
  logic [ID_W-1:0]      rd_data_r;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 accept, in_range, mem_we, need_push;
  logic [NUM_FACES-1:0] border;

  assign accept = in_valid && !in_stall;
  assign in_range = (int'(in_cell_x) < CHUNK_SIDE) && (int'(in_cell_y) < CHUNK_SIDE) &&
                    (int'(in_cell_z) < CHUNK_SIDE);
  assign mem_we = accept && (in_op == OP_WRITE) && in_range;
  assign in_stall = (state_r != S_IDLE);

  assign border[0] = (x_r == '0);
  assign border[1] = (y_r == '0);
  assign border[2] = (z_r == '0);
  assign border[3] = (int'(x_r) == CHUNK_SIDE - 1);
  assign border[4] = (int'(y_r) == CHUNK_SIDE - 1);
  assign border[5] = (int'(z_r) == CHUNK_SIDE - 1);

  // A neighbour beyond the border is not read; the cell itself is read instead.
  always_comb begin
    unique case (rd_idx_r)
      3'd1:    rd_addr = border[0] ? cell_addr(x_r, y_r, z_r)
                                   : cell_addr(x_r - 1'b1, y_r, z_r);
      3'd2:    rd_addr = border[1] ? cell_addr(x_r, y_r, z_r)
                                   : cell_addr(x_r, y_r - 1'b1, z_r);
      3'd3:    rd_addr = border[2] ? cell_addr(x_r, y_r, z_r)
                                   : cell_addr(x_r, y_r, z_r - 1'b1);
      3'd4:    rd_addr = border[3] ? cell_addr(x_r, y_r, z_r)
                                   : cell_addr(x_r + 1'b1, y_r, z_r);
      3'd5:    rd_addr = border[4] ? cell_addr(x_r, y_r, z_r)
                                   : cell_addr(x_r, y_r + 1'b1, z_r);
      3'd6:    rd_addr = border[5] ? cell_addr(x_r, y_r, z_r)
                                   : cell_addr(x_r, y_r, z_r + 1'b1);
      default: rd_addr = cell_addr(x_r, y_r, z_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[cell_addr(in_cell_x, in_cell_y, in_cell_z)] <= in_block_id;
    end
    rd_data_r <= store[rd_addr];
  end

  assign need_push     = (kind_r == JOB_CLEAR) || (solid_r && (vis_r != '0));
  assign push          = (state_r == S_PUSH) && need_push && !q_status.full;
  assign push_job.kind = kind_r;
  assign push_job.x    = x_r;
  assign push_job.y    = y_r;
  assign push_job.z    = z_r;
  assign push_job.vis  = vis_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pend_r   <= 1'b0;
      rd_idx_r <= '0;
    end else begin
      if (pend_r) begin
        if (pend_idx_r == 3'd0) begin
          solid_r <= (rd_data_r != air_id);
        end else begin
          vis_r[pend_idx_r - 3'd1] <= border[pend_idx_r - 3'd1] || (rd_data_r == air_id);
        end
      end
      unique case (state_r)
        S_IDLE: begin
          pend_r <= 1'b0;
          if (accept) begin
            x_r      <= in_cell_x;
            y_r      <= in_cell_y;
            z_r      <= in_cell_z;
            solid_r  <= 1'b0;
            vis_r    <= '0;
            rd_idx_r <= '0;
            if (in_op == OP_CLEAR) begin
              kind_r  <= JOB_CLEAR;
              state_r <= S_PUSH;
            end else if (in_op == OP_MESH && in_range) begin
              kind_r  <= JOB_MESH;
              state_r <= S_READ;
            end
          end
        end
        S_READ: begin
          pend_r     <= 1'b1;
          pend_idx_r <= rd_idx_r;
          rd_idx_r   <= rd_idx_r + 3'd1;
          if (rd_idx_r == 3'd6) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          pend_r  <= 1'b0;
          state_r <= S_PUSH;
        end
        S_PUSH: begin
          if (!need_push || !q_status.full) begin
            state_r <= S_IDLE;
          end
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_mesh_job_visible: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_job.kind == JOB_MESH) |-> (push_job.vis != '0) && solid_r)
    else $error("mesh job queued with no visible face");
  a_store_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |=> !$past(mem_we))
    else $error("store written during a neighbour scan");
`endif

endmodule

`default_nettype wire

// ===== rtl/vfcm_back.sv =====
// ----------------------------------------------------------------------------
// Voxel face cull mesher back end
// Walks the visible faces of a queued job and emits four vertices per face.
// ----------------------------------------------------------------------------
`default_nettype none

module vfcm_back (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire vfcm_pkg::q_status_t                  q_status,
  input  wire vfcm_pkg::job_t                       pop_job,
  output logic                                      pop,
  input  wire logic signed [vfcm_pkg::CHUNK_W-1:0]  chunk_x,
  input  wire logic signed [vfcm_pkg::CHUNK_W-1:0]  chunk_y,
  input  wire logic signed [vfcm_pkg::CHUNK_W-1:0]  chunk_z,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [vfcm_pkg::POS_W-1:0]         out_pos_x,
  output logic signed [vfcm_pkg::POS_W-1:0]         out_pos_y,
  output logic signed [vfcm_pkg::POS_W-1:0]         out_pos_z,
  output logic [2:0]                                out_face,
  output logic [1:0]                                out_tex_kind,
  output logic [1:0]                                out_corner,
  output logic [vfcm_pkg::VIDX_W-1:0]               out_vertex_index,
  output logic                                      out_last
);
  import vfcm_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t               state_r;
  logic [CELL_W-1:0]    x_r, y_r, z_r;
  logic [NUM_FACES-1:0] rem_r;
  logic [1:0]           corner_r;
  logic [VIDX_W-1:0]    vcount_r;
  logic                 out_valid_r;

  logic [2:0]           face;
  logic [NUM_FACES-1:0] rem_after;
  logic [2:0]           sign;
  logic                 load, final_vtx;

  always_comb begin
    face = '0;
    for (int i = NUM_FACES - 1; i >= 0; i--) begin
      if (rem_r[i]) begin
        face = 3'(i);
      end
    end
  end

  assign rem_after = rem_r & ~(NUM_FACES'(1) << face);
  assign final_vtx = (corner_r == CORNER_LAST) && (rem_after == '0);
  assign sign      = CORNER_SIGN[face][corner_r];
  assign load      = (state_r == S_RUN) && (!out_valid_r || !out_stall);
  assign pop       = (state_r == S_IDLE) && !q_status.empty;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (load) begin
      out_pos_x        <= half_pos(chunk_x, x_r, sign[2]);
      out_pos_y        <= half_pos(chunk_y, y_r, sign[1]);
      out_pos_z        <= half_pos(chunk_z, z_r, sign[0]);
      out_face         <= face;
      out_tex_kind     <= FACE_KIND[face];
      out_corner       <= corner_r;
      out_vertex_index <= vcount_r;
      out_last         <= final_vtx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      vcount_r    <= '0;
      corner_r    <= '0;
      rem_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (pop) begin
            if (pop_job.kind == JOB_CLEAR) begin
              vcount_r <= '0;
            end else begin
              x_r      <= pop_job.x;
              y_r      <= pop_job.y;
              z_r      <= pop_job.z;
              rem_r    <= pop_job.vis;
              corner_r <= '0;
              state_r  <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (load) begin
            vcount_r <= vcount_r + 1'b1;
            corner_r <= corner_r + 2'd1;
            if (corner_r == CORNER_LAST) begin
              rem_r <= rem_after;
              if (rem_after == '0) begin
                state_r <= S_IDLE;
              end
            end
          end
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_last_on_corner: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last) |-> (out_corner == CORNER_LAST))
    else $error("last flag on a vertex that does not close a quad");
  a_run_has_face: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (rem_r != '0))
    else $error("emitter running with no face left");
`endif

endmodule

`default_nettype wire

// ===== rtl/voxel_face_cull_mesher_unit.sv =====
// ----------------------------------------------------------------------------
// Voxel face cull mesher
// Face-culling mesher for one cubic chunk: block store, face test, vertices.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Payload
//  in_      input      in_valid / in_stall  op, cell_x, cell_y, cell_z, block_id
//  out_     output     out_valid/out_stall  pos_x/y/z, face, tex_kind, corner,
//                                           vertex_index, last
//  cfg_     input      cfg_we               cfg_index, cfg_wdata
//
// In the front end a write or ignored transaction ends in S_IDLE, a clear adds
// a queue push, and a mesh makes seven reads of the single store read port, a
// drain step and a push if the cell is solid with a visible face. The back end
// emits one vertex per cycle when not stalled, four per visible face. Reset is
// synchronous and clears control state only; the block store is undefined
// until written. Output stalls fill the job queue and then hold in_stall high.
`default_nettype none

module voxel_face_cull_mesher_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [1:0]                           in_op,
  input  wire logic [vfcm_pkg::CELL_W-1:0]          in_cell_x,
  input  wire logic [vfcm_pkg::CELL_W-1:0]          in_cell_y,
  input  wire logic [vfcm_pkg::CELL_W-1:0]          in_cell_z,
  input  wire logic [vfcm_pkg::ID_W-1:0]            in_block_id,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [vfcm_pkg::POS_W-1:0]         out_pos_x,
  output logic signed [vfcm_pkg::POS_W-1:0]         out_pos_y,
  output logic signed [vfcm_pkg::POS_W-1:0]         out_pos_z,
  output logic [2:0]                                out_face,
  output logic [1:0]                                out_tex_kind,
  output logic [1:0]                                out_corner,
  output logic [vfcm_pkg::VIDX_W-1:0]               out_vertex_index,
  output logic                                      out_last,
  input  wire logic                                 cfg_we,
  input  wire logic [1:0]                           cfg_index,
  input  wire logic [vfcm_pkg::CHUNK_W-1:0]         cfg_wdata
);
  import vfcm_pkg::*;

  logic signed [CHUNK_W-1:0] chunk_x_r, chunk_y_r, chunk_z_r;
  logic [ID_W-1:0]           air_id_r;
  logic                      push, pop;
  job_t                      push_job, pop_job;
  q_status_t                 q_status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_x_r <= '0;
      chunk_y_r <= '0;
      chunk_z_r <= '0;
      air_id_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHUNK_X: chunk_x_r <= cfg_wdata;
        CFG_CHUNK_Y: chunk_y_r <= cfg_wdata;
        CFG_CHUNK_Z: chunk_z_r <= cfg_wdata;
        CFG_AIR_ID:  air_id_r  <= cfg_wdata[ID_W-1:0];
      endcase
    end
  end

  vfcm_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_op       (in_op),
    .in_cell_x   (in_cell_x),
    .in_cell_y   (in_cell_y),
    .in_cell_z   (in_cell_z),
    .in_block_id (in_block_id),
    .air_id      (air_id_r),
    .q_status    (q_status),
    .push        (push),
    .push_job    (push_job)
  );

  vfcm_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .status   (q_status)
  );

  vfcm_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_status         (q_status),
    .pop_job          (pop_job),
    .pop              (pop),
    .chunk_x          (chunk_x_r),
    .chunk_y          (chunk_y_r),
    .chunk_z          (chunk_z_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y),
    .out_pos_z        (out_pos_z),
    .out_face         (out_face),
    .out_tex_kind     (out_tex_kind),
    .out_corner       (out_corner),
    .out_vertex_index (out_vertex_index),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire
